// ===== src/crc16_pkg.sv =====
// ----------------------------------------------------------------------------
// crc16_pkg
// Shared types, constants and the byte-wise CRC-16 (0x1021) update function.
// ----------------------------------------------------------------------------
package crc16_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [7:0]  ESC_MIN  = 8'hFD;

  // One packet byte as it sits in the input register.
  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       last_byte;
  } stage_t;

  // Byte-wise swap-and-xor form of the CCITT polynomial update.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] x;
    logic [7:0]  lo;
    x  = {crc[7:0], crc[15:8]} ^ {8'h00, b};
    x  = x ^ {12'h000, x[7:4]};
    lo = x[7:0];
    x  = x ^ {lo[3:0], 12'h000} ^ {3'b000, lo, 5'b00000};
    return x;
  endfunction

  function automatic logic is_escape(input logic [15:0] sum);
    return (sum[15:8] >= ESC_MIN) || (sum[7:0] >= ESC_MIN);
  endfunction

endpackage

// ===== src/crc16_in_reg.sv =====
// ----------------------------------------------------------------------------
// crc16_in_reg
// Input register: holds one accepted byte until the engine consumes it.
// ----------------------------------------------------------------------------
module crc16_in_reg
  import crc16_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       advance,
  output stage_t     stage
);

  // The register can load when it is empty or its byte moves on this cycle.
  assign byte_stall = stage.valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (!byte_stall) begin
      stage.valid <= byte_valid;
    end
    if (!byte_stall) begin
      stage.data_byte <= data_byte;
      stage.last_byte <= last_byte;
    end
  end

endmodule

// ===== src/crc16_engine.sv =====
// ----------------------------------------------------------------------------
// crc16_engine
// Running CRC register, one-byte fold, and the result register.
// ----------------------------------------------------------------------------
module crc16_engine
  import crc16_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  stage_t      stage,
  output logic        advance,
  output logic        sum_valid,
  input  logic        sum_stall,
  output logic [15:0] checksum,
  output logic        needs_escape
);

  logic [15:0] running_crc;
  logic [15:0] crc_next;
  logic [15:0] sum_next;
  logic        out_free;

  assign crc_next = crc_fold(running_crc, stage.data_byte);
  assign sum_next = ~crc_next;

  // A byte that is not last never needs the result register.
  assign out_free = !sum_valid || !sum_stall;
  assign advance  = stage.valid && (!stage.last_byte || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= CRC_INIT;
      sum_valid   <= 1'b0;
    end else begin
      if (advance) begin
        running_crc <= stage.last_byte ? CRC_INIT : crc_next;
      end
      if (out_free) begin
        sum_valid <= advance && stage.last_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && stage.last_byte) begin
      checksum     <= sum_next;
      needs_escape <= is_escape(sum_next);
    end
  end

endmodule

// ===== src/crc16_ccitt_packet_checksum_top.sv =====
// ----------------------------------------------------------------------------
// crc16_ccitt_packet_checksum_top
// Packet checksum: CRC-16/CCITT (0x1021, init 0xFFFF), complemented result.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake              | Payload
//   --------+------------------------+---------------------------------
//   byte    | byte_valid, byte_stall | data_byte[7:0], last_byte
//   sum     | sum_valid,  sum_stall  | checksum[15:0], needs_escape
//
// A byte transaction completes at an edge where byte_valid is high and
// byte_stall is low; the sum channel works the same way.
// One byte is taken every cycle while byte_stall is low. A checksum
// reaches the sum ports from the input register through one fold of
// logic into the result register.
// Reset (rst, synchronous, active high) empties both registers and returns
// the running CRC to 0xFFFF.
// A stalled checksum holds the result register; bytes that are not last keep
// flowing, and the next last byte waits in the input register.
// ----------------------------------------------------------------------------
module crc16_ccitt_packet_checksum_top
  import crc16_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        sum_valid,
  input  logic        sum_stall,
  output logic [15:0] checksum,
  output logic        needs_escape
);

  // The input register and the engine trade the held byte and its advance.
  stage_t stage;
  logic   advance;

  crc16_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .advance    (advance),
    .stage      (stage)
  );

  // The engine folds the held byte into the running CRC and, on the last
  // byte of a packet, loads the complemented CRC and escape flag.
  crc16_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .stage        (stage),
    .advance      (advance),
    .sum_valid    (sum_valid),
    .sum_stall    (sum_stall),
    .checksum     (checksum),
    .needs_escape (needs_escape)
  );

endmodule

// ===== src/crc16_checker.sv =====
// ----------------------------------------------------------------------------
// crc16_checker
// Port-level checks on the packet checksum block.
// ----------------------------------------------------------------------------
module crc16_checker
  import crc16_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        byte_valid,
  input logic        byte_stall,
  input logic        last_byte,
  input logic        sum_valid,
  input logic        sum_stall,
  input logic [15:0] checksum,
  input logic        needs_escape
);

  a_sum_hold : assert property (@(posedge clk) disable iff (rst)
    sum_valid && sum_stall |=> sum_valid && $stable(checksum) && $stable(needs_escape))
    else $error("stalled checksum transaction changed");

  a_escape_flag : assert property (@(posedge clk) disable iff (rst)
    sum_valid |-> needs_escape == ((checksum[15:8] >= ESC_MIN) || (checksum[7:0] >= ESC_MIN)))
    else $error("escape flag disagrees with checksum");

  // A fresh result can only follow an accepted last byte.
  a_rise_after_last : assert property (@(posedge clk) disable iff (rst)
    $rose(sum_valid) |-> $past(byte_valid && !byte_stall && last_byte, 2) ||
                         $past(byte_valid && !byte_stall && last_byte, 1))
    else $error("checksum appeared without a last byte");

  // The input side only stalls while a finished checksum is waiting.
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> sum_valid && sum_stall)
    else $error("input stalled with the result path free");

endmodule

bind crc16_ccitt_packet_checksum_top crc16_checker u_crc16_checker (
  .clk          (clk),
  .rst          (rst),
  .byte_valid   (byte_valid),
  .byte_stall   (byte_stall),
  .last_byte    (last_byte),
  .sum_valid    (sum_valid),
  .sum_stall    (sum_stall),
  .checksum     (checksum),
  .needs_escape (needs_escape)
);

// ===== verif/tb_crc16_ccitt_packet_checksum_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_crc16_ccitt_packet_checksum_top
// Self-checking bench for the CRC-16/CCITT packet checksum block.
// Packets of random length and content are fed through the byte channel.
// A bit-serial CRC predictor queues the expected checksum and escape flag.
// A monitor compares each sum transaction with the oldest queued entry.
// Both channels idle at random, and one phase holds the sum channel off long
// enough to back the block up into its byte input.
// ----------------------------------------------------------------------------
module tb_crc16_ccitt_packet_checksum_top;
  import crc16_pkg::*;

  // The bit-serial form of the CCITT polynomial (x^16 + x^12 + x^5 + 1).
  // It is fed MSB first, which matches the byte-wise swap form of the design.
  localparam logic [15:0] CCITT_POLY   = 16'h1021;
  localparam int          CLK_HALF     = 6;
  localparam int          RESET_CYCLES = 10;
  // A checksum shows up after its last byte passes the input and result
  // registers. This settle time adds a margin before the bench moves on.
  localparam int          DRAIN_CYCLES = 8;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          RANDOM_BYTES = 1400;

  typedef struct packed {
    logic [15:0] checksum;
    logic        needs_escape;
  } packet_sum_t;

  logic        clk;
  logic        rst;
  logic        byte_valid;
  logic        byte_stall;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        sum_valid;
  logic        sum_stall;
  logic [15:0] checksum;
  logic        needs_escape;

  // Checksums still owed by the block, oldest first.
  packet_sum_t expected_sums[$];
  // The bench's own copy of the running CRC of the packet in progress.
  logic [15:0] packet_crc = CRC_INIT;
  int          mismatch_count = 0;
  // When set, neither side idles. This gives stretches of back-to-back traffic.
  bit          quiet = 1'b0;
  // A request for a long receiver hold-off. The receiver process picks it up.
  int          hold_request = 0;

  crc16_ccitt_packet_checksum_top uut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .sum_valid    (sum_valid),
    .sum_stall    (sum_stall),
    .checksum     (checksum),
    .needs_escape (needs_escape)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Shift one byte through the CRC one bit at a time. This is independent
  // of the table-free byte-wise form that the design uses.
  function automatic logic [15:0] crc_after_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    acc = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (acc[15]) begin
        acc = {acc[14:0], 1'b0} ^ CCITT_POLY;
      end else begin
        acc = {acc[14:0], 1'b0};
      end
    end
    return acc;
  endfunction

  // A checksum byte of 0xFD or above collides with the link's framing codes.
  function automatic logic sum_needs_escape(input logic [15:0] sum);
    return (sum[15:8] >= ESC_MIN) || (sum[7:0] >= ESC_MIN);
  endfunction

  // Most gaps are zero or short. A few are long, so that idle cycles land on
  // every phase of the two-stage pipeline.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Offer one byte after a random gap and hold it until the block takes it.
  // The predictor is advanced only when the transaction actually completes.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    packet_sum_t sum;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      byte_valid <= 1'b0;
    end
    @(negedge clk);
    byte_valid <= 1'b1;
    data_byte  <= b;
    last_byte  <= last;
    // The payload stays put while the block stalls.
    do @(posedge clk); while (byte_stall);
    packet_crc = crc_after_byte(packet_crc, b);
    if (last) begin
      sum.checksum     = ~packet_crc;
      sum.needs_escape = sum_needs_escape(sum.checksum);
      expected_sums.push_back(sum);
      packet_crc = CRC_INIT;
    end
  endtask

  task automatic send_random_packet(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  // Mostly short packets, so that checksums come often, with a few long ones.
  function automatic int pick_packet_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return $urandom_range(1, 4);
    end else if (r < 90) begin
      return $urandom_range(5, 16);
    end
    return $urandom_range(17, 64);
  endfunction

  // Drop valid, then wait until every owed checksum has arrived. The
  // watchdog below catches the case where one never does.
  task automatic wait_for_sums();
    @(negedge clk);
    byte_valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Each single-byte packet is checksummed from the initial value on its own.
  task automatic test_single_byte_packets();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h55, 1'b1);
    send_byte(8'hAA, 1'b1);
    wait_for_sums();
  endtask

  // The usual check string "123456789" goes through as one packet.
  task automatic test_check_string();
    for (int i = 1; i <= 9; i++) begin
      send_byte(8'h30 + 8'(i), i == 9);
    end
    wait_for_sums();
  endtask

  // Packets made of all-zero and all-one bytes, with the last mark on the
  // opposite extreme.
  task automatic test_byte_extremes();
    for (int i = 0; i < 4; i++) begin
      send_byte((i == 3) ? 8'hFF : 8'h00, i == 3);
    end
    for (int i = 0; i < 4; i++) begin
      send_byte((i == 3) ? 8'h00 : 8'hFF, i == 3);
    end
    wait_for_sums();
  endtask

  // Random packets in four phases. The second phase runs without idling
  // on either side.
  task automatic test_random_packets();
    int sent;
    for (int phase = 0; phase < 4; phase++) begin
      quiet = (phase == 1);
      sent  = 0;
      while (sent < RANDOM_BYTES / 4) begin
        int len;
        len = pick_packet_len();
        send_random_packet(len);
        sent += len;
      end
      wait_for_sums();
    end
    quiet = 1'b0;
  endtask

  // The receiver holds off for a long stretch while short packets keep
  // coming. The result register fills, then the next last byte parks in the
  // input register, and the byte channel has to stall.
  task automatic test_sum_backpressure();
    quiet = 1'b1;
    @(posedge clk);
    hold_request = HOLD_CYCLES;
    for (int i = 0; i < 20; i++) begin
      send_random_packet($urandom_range(1, 2));
    end
    wait_for_sums();
    quiet = 1'b0;
  endtask

  // Receiver: random stalls, short ones mostly, plus the long hold-off on
  // request. The hold-off is counted down here, one cycle at a time.
  initial begin : sum_receiver
    int stall_run;
    int hold_run;
    int r;
    sum_stall = 1'b0;
    stall_run = 0;
    hold_run  = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_run     = hold_request;
        hold_request = 0;
      end
      if (hold_run > 0) begin
        sum_stall <= 1'b1;
        hold_run--;
      end else if (quiet) begin
        sum_stall <= 1'b0;
        stall_run = 0;
      end else if (stall_run > 0) begin
        sum_stall <= 1'b1;
        stall_run--;
      end else begin
        sum_stall <= 1'b0;
        r = $urandom_range(0, 99);
        if (r < 15) begin
          stall_run = $urandom_range(1, 3);
        end else if (r < 18) begin
          stall_run = $urandom_range(10, 40);
        end
      end
    end
  end

  // Monitor: every completed sum transaction must match the oldest queued
  // expectation, field by field.
  initial begin : sum_monitor
    packet_sum_t want;
    forever begin
      @(posedge clk);
      if (!rst && sum_valid && !sum_stall) begin
        if (expected_sums.size() == 0) begin
          report_mismatch("unexpected checksum", checksum, 16'h0000);
        end else begin
          want = expected_sums.pop_front();
          if (checksum !== want.checksum) begin
            report_mismatch("checksum", checksum, want.checksum);
          end
          if (needs_escape !== want.needs_escape) begin
            report_mismatch("needs_escape", 16'(needs_escape), 16'(want.needs_escape));
          end
        end
      end
    end
  end

  // Watchdog: far beyond the slowest correct run, which has every byte
  // waiting out a long gap and a long stall.
  initial begin : watchdog
    #(10_000_000);
    $display("FAIL");
    $finish;
  end

  // Main sequence. Reset is applied once, then each test runs in turn.
  initial begin
    rst        = 1'b1;
    byte_valid = 1'b0;
    data_byte  = 8'h00;
    last_byte  = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_single_byte_packets();
    test_check_string();
    test_byte_extremes();
    test_random_packets();
    test_sum_backpressure();

    if (mismatch_count == 0 && expected_sums.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
